// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the matrix multiply RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ===== hdl/fmm_pkg.sv =====
// Shared constants, types and field helpers for the Mersenne field matrix multiply.
// No dependencies.
`default_nettype none
package fmm_pkg;

	localparam int MAX_DIM      = 16;
	localparam int MERSENNE_EXP = 31;
	localparam int ELEM_W       = MERSENNE_EXP;
	localparam int COL_W        = $clog2(MAX_DIM);
	localparam int DIM_W        = $clog2(MAX_DIM) + 1;
	localparam int STORE_DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int CNT_W        = ADDR_W + 1;
	localparam int CFG_W        = 5;
	localparam int S_TDATA_W    = ((ELEM_W + 7) / 8) * 8;
	localparam int M_TDATA_W    = ((ELEM_W + COL_W + 7) / 8) * 8;

	localparam logic [ELEM_W-1:0] FIELD_P = {ELEM_W{1'b1}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef enum logic {
		OP_LOAD_B   = 1'b0,
		OP_STREAM_A = 1'b1
	} opcode_t;

	typedef enum logic {
		REG_INNER_SIZE = 1'b0,
		REG_OUT_COLS   = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic             valid;
		logic [COL_W-1:0] col;
	} tag_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > CFG_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		else
			r = DIM_W'(v);
		return r;
	endfunction

	function automatic logic [ELEM_W-1:0] add_mod(input logic [ELEM_W-1:0] a,
		input logic [ELEM_W-1:0] b);
		logic [ELEM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, FIELD_P})
			s = s - {1'b0, FIELD_P};
		return s[ELEM_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/fmm_mulmod.sv =====
// Three-stage modular multiplier: product, Mersenne fold, final reduction.
// Depends on fmm_pkg.
`default_nettype none
module fmm_mulmod
	import fmm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ELEM_W-1:0] a,
	input  logic [ELEM_W-1:0] b,
	input  tag_t              tag_in,
	output logic [ELEM_W-1:0] prod,
	output tag_t              tag_out,
	output logic              busy
);

	logic [2*ELEM_W-1:0] prod_s2;
	logic [ELEM_W:0]     sum_s3;
	logic [ELEM_W-1:0]   res_s4;
	tag_t                tag_s2, tag_s3, tag_s4;
	logic [ELEM_W:0]     fold_t;
	logic [ELEM_W:0]     fold_r;

	always_comb begin
		fold_t = {1'b0, sum_s3[ELEM_W-1:0]} + (ELEM_W+1)'(sum_s3[ELEM_W]);
		if (fold_t >= {1'b0, FIELD_P})
			fold_r = fold_t - {1'b0, FIELD_P};
		else
			fold_r = fold_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s2 <= tag_in;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= (2*ELEM_W)'(a) * (2*ELEM_W)'(b);
		sum_s3  <= {1'b0, prod_s2[ELEM_W-1:0]} + {1'b0, prod_s2[2*ELEM_W-1:ELEM_W]};
		res_s4  <= fold_r[ELEM_W-1:0];
	end

	assign prod    = res_s4;
	assign tag_out = tag_s4;
	assign busy    = tag_s2.valid | tag_s3.valid | tag_s4.valid;

endmodule
`default_nettype wire

// ===== hdl/fmm_cell.sv =====
// One accumulator cell of the rotating row; optionally adds a product on the way in.
// Depends on fmm_pkg.
`default_nettype none
module fmm_cell
	import fmm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  logic [ELEM_W-1:0] din,
	input  logic              add_en,
	input  logic [ELEM_W-1:0] addend,
	output logic [ELEM_W-1:0] acc
);

	logic [ELEM_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (shift) begin
			if (add_en)
				acc_q <= add_mod(din, addend);
			else
				acc_q <= din;
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

// ===== hdl/mersenne_field_matrix_multiply_unit.sv =====
// Matrix multiply modulo 2^31-1: B store, modular multiplier and rotating accumulator row.
// Depends on fmm_pkg, fmm_mulmod, fmm_cell and assert_macros.svh.
// B load: transactions are taken while idle, one B element each. A element: the accept cycle,
// then one B store read (one column) per cycle into the multiplier, then a drain until the
// multiplier is empty. At row end the row is emitted, stalling while m_tready holds the output.
// Reset: accumulators and counters zero, both dimension registers 16; B store not cleared.
`default_nettype none
`include "assert_macros.svh"
module mersenne_field_matrix_multiply_unit
	import fmm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // elem_value
	input  logic                 s_tuser,   // opcode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // product_value, col_index
	output logic                 m_tlast,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	state_t            state_q, state_d;
	logic [CFG_W-1:0]  inner_size_q, out_cols_q;
	logic [DIM_W-1:0]  inner, oc, oc_q;
	logic [CNT_W-1:0]  b_cnt_q;
	logic [COL_W-1:0]  a_cnt_q, k_q, j_q, e_q;
	logic              row_end_q, row_end;
	logic [ELEM_W-1:0] a_q, elem, elem_f;
	logic              in_fire, is_a;
	logic [CNT_W-1:0]  b_total;
	logic [ADDR_W-1:0] b_wr_addr, rd_addr;
	logic [ADDR_W+1:0] rd_full;
	logic [ELEM_W-1:0] b_mem [STORE_DEPTH];
	logic [ELEM_W-1:0] b_rd_s1;
	tag_t              tag_s1, tag_s4;
	logic [ELEM_W-1:0] prod_s4;
	logic              mm_busy;
	logic [ELEM_W-1:0] acc [MAX_DIM];
	logic              ring_shift, tail_add, emit_step, out_room, out_load, emit_live;
	logic [ELEM_W-1:0] tail_din;
	logic              m_tvalid_q, out_last_q;
	logic [ELEM_W-1:0] out_val_q;
	logic [COL_W-1:0]  out_col_q;

	assign inner    = clamp_dim(inner_size_q);
	assign oc       = clamp_dim(out_cols_q);
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid & s_tready;
	assign is_a     = (opcode_t'(s_tuser) == OP_STREAM_A);
	assign elem     = s_tdata[ELEM_W-1:0];
	assign elem_f   = (elem == FIELD_P) ? '0 : elem;
	assign row_end  = ({1'b0, a_cnt_q} + DIM_W'(1)) >= inner;

	assign b_total   = CNT_W'(inner) * CNT_W'(oc);
	assign b_wr_addr = (b_cnt_q >= b_total) ? '0 : b_cnt_q[ADDR_W-1:0];
	assign rd_full   = (ADDR_W+2)'(k_q) * (ADDR_W+2)'(oc_q) + (ADDR_W+2)'(j_q);
	assign rd_addr   = rd_full[ADDR_W-1:0];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_size_q <= CFG_W'(MAX_DIM);
			out_cols_q   <= CFG_W'(MAX_DIM);
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_INNER_SIZE: inner_size_q <= cfg_wdata;
				REG_OUT_COLS:   out_cols_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// B store
	always_ff @(posedge clk) begin
		if (in_fire && !is_a)
			b_mem[b_wr_addr] <= elem_f;
	end

	always_ff @(posedge clk) begin
		b_rd_s1 <= b_mem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			b_cnt_q   <= '0;
			a_cnt_q   <= '0;
			k_q       <= '0;
			oc_q      <= DIM_W'(MAX_DIM);
			row_end_q <= 1'b0;
			j_q       <= '0;
			e_q       <= '0;
			tag_s1    <= '0;
		end else begin
			state_q      <= state_d;
			tag_s1.valid <= (state_q == ST_ISSUE);
			tag_s1.col   <= j_q;
			if (in_fire && !is_a)
				b_cnt_q <= CNT_W'(b_wr_addr) + CNT_W'(1);
			if (in_fire && is_a) begin
				k_q       <= a_cnt_q;
				oc_q      <= oc;
				row_end_q <= row_end;
				a_cnt_q   <= row_end ? '0 : a_cnt_q + COL_W'(1);
				j_q       <= '0;
				e_q       <= '0;
			end
			if (state_q == ST_ISSUE)
				j_q <= j_q + COL_W'(1);
			if (state_q == ST_EMIT && emit_step)
				e_q <= e_q + COL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && is_a)
			a_q <= elem_f;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && is_a)
					state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (j_q == COL_W'(MAX_DIM - 1))
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!tag_s1.valid && !mm_busy)
					state_d = row_end_q ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (emit_step && e_q == COL_W'(MAX_DIM - 1))
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	fmm_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.a       (a_q),
		.b       (b_rd_s1),
		.tag_in  (tag_s1),
		.prod    (prod_s4),
		.tag_out (tag_s4),
		.busy    (mm_busy)
	);

	// accumulator row: head leaves, tail takes head plus product, or zero while emitting
	assign out_room   = !m_tvalid_q || m_tready;
	assign emit_live  = ({1'b0, e_q} < oc_q);
	assign emit_step  = !emit_live || out_room;
	assign out_load   = (state_q == ST_EMIT) && emit_live && out_room;
	assign ring_shift = (state_q == ST_EMIT) ? emit_step : tag_s4.valid;
	assign tail_add   = (state_q != ST_EMIT) && tag_s4.valid && ({1'b0, tag_s4.col} < oc_q);
	assign tail_din   = (state_q == ST_EMIT) ? '0 : acc[0];

	for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
		fmm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (ring_shift),
			.din    ((i == MAX_DIM - 1) ? tail_din : acc[(i + 1) % MAX_DIM]),
			.add_en ((i == MAX_DIM - 1) ? tail_add : 1'b0),
			.addend (prod_s4),
			.acc    (acc[i])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_val_q  <= acc[0];
			out_col_q  <= e_q;
			out_last_q <= (({1'b0, e_q} + DIM_W'(1)) == oc_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'({out_col_q, out_val_q});
	assign m_tlast  = out_last_q;

	`ASSERT_NEVER(a_pipe_empty_emit, (state_q == ST_EMIT) && (tag_s1.valid || mm_busy), "products in flight while emitting")
	`ASSERT_NEVER(a_pipe_empty_idle, (state_q == ST_IDLE) && (tag_s1.valid || mm_busy), "products in flight while idle")
	`ASSERT_PROP(a_issue_end, (state_q == ST_ISSUE) && (j_q == COL_W'(MAX_DIM - 1)) |=> (state_q == ST_DRAIN), "issue pass did not end")
	`ASSERT_PROP(a_stream_starts, in_fire && is_a |=> (state_q == ST_ISSUE) && (j_q == '0), "A element did not start issue")
	`ASSERT_NEVER(a_load_count_range, b_cnt_q > CNT_W'(STORE_DEPTH), "B load count beyond store")

endmodule
`default_nettype wire
